/* hdl/b64c_pkg.sv */
`default_nettype none

package b64c_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_CHAR = 2'd1,
        STATUS_BAD_LEN  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        JOB_ENC = 2'd0,
        JOB_DEC = 2'd1,
        JOB_ERR = 2'd2
    } job_kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        status_t    status;
    } out_item_t;

    // one classified group handed from front to back
    typedef struct packed {
        job_kind_t   kind;
        logic [23:0] bits;
        logic [3:0]  slots;
        logic [3:0]  pads;
        logic        last;
        status_t     status;
    } job_t;

    // bit 6 set means not a base64 character
    function automatic logic [6:0] b64c_char_value(input logic [7:0] c);
        logic [6:0] v;
        v = 7'h40;
        if (c inside {[8'h41:8'h5A]})
        begin
            v = {1'b0, 6'(c - 8'h41)};
        end
        else if (c inside {[8'h61:8'h7A]})
        begin
            v = {1'b0, 6'(c - 8'h61 + 8'd26)};
        end
        else if (c inside {[8'h30:8'h39]})
        begin
            v = {1'b0, 6'(c - 8'h30 + 8'd52)};
        end
        else if (c == CHAR_PLUS)
        begin
            v = 7'd62;
        end
        else if (c == CHAR_SLASH)
        begin
            v = 7'd63;
        end
        else if (c == CHAR_PAD)
        begin
            v = 7'd0;
        end
        return v;
    endfunction

    function automatic logic [7:0] b64c_char(input logic [5:0] v);
        logic [7:0] c;
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)
        begin
            c = 8'h41 + w;
        end
        else if (v < 6'd52)
        begin
            c = 8'h61 + w - 8'd26;
        end
        else if (v < 6'd62)
        begin
            c = 8'h30 + w - 8'd52;
        end
        else if (v == 6'd62)
        begin
            c = CHAR_PLUS;
        end
        else
        begin
            c = CHAR_SLASH;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hdl/base64_codec_unit.sv */
// Streaming Base64 codec (standard alphabet, '=' padding). cfg_we/cfg_wdata set the
// direction (0 encode, 1 decode) and clear any partial group; write it only while the
// block is idle. Bytes or characters are pushed one per cycle while full is low; a
// message ends on the beat with in_last. The front end classifies each beat in the cycle
// it is taken and hands finished groups through a small job queue to the back end, which
// drives one result per cycle into the output register while that register is empty or
// popped, so the output port sets the pace: encoding gives four characters per three
// bytes, decoding up to three bytes per four characters (one character per cycle). A
// finished group passes from the job queue through the back end's job register into the
// output register. An invalid character returns status 1 and drops the rest of the
// message; a decode message whose length is not a multiple of four returns status 2.
// Status beats carry out_byte 0 and out_last 1.
`default_nettype none

module base64_codec_unit #(
    parameter int QUEUE_DEPTH = b64c_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_wdata,
    input  wire logic                push,
    output logic                     full,
    input  wire b64c_pkg::in_item_t  in_item,
    output logic                     empty,
    input  wire logic                pop,
    output b64c_pkg::out_item_t      out_item
);
    import b64c_pkg::*;

    logic accept;
    logic job_push;
    job_t job_front;
    logic q_full;
    logic q_valid;
    logic q_pop;
    job_t q_job;

    assign full   = q_full;
    assign accept = push && !q_full;

    b64c_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .in_item   (in_item),
        .job_push  (job_push),
        .job       (job_front)
    );

    b64c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_push),
        .wr_job   (job_front),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_job   (q_job)
    );

    b64c_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_in    (q_job),
        .job_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

/* hdl/b64c_front.sv */
`default_nettype none

module b64c_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_wdata,
    input  wire logic                accept,
    input  wire b64c_pkg::in_item_t  in_item,
    output logic                     job_push,
    output b64c_pkg::job_t           job
);
    import b64c_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [23:0] grp_reg, grp_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pad_reg, pad_next;
    logic        err_reg, err_next;

    logic [23:0] grp_new;
    logic [6:0]  ch_val;
    logic [7:0]  b;
    logic        last;

    assign b      = in_item.in_byte;
    assign last   = in_item.in_last;
    assign ch_val = b64c_char_value(b);

    // place the new byte or sextet into the group, top down
    always_comb
    begin
        grp_new = grp_reg;
        if (mode_reg == MODE_ENCODE)
        begin
            case (cnt_reg)
                2'd0:    grp_new[23:16] = b;
                2'd1:    grp_new[15:8]  = b;
                default: grp_new[7:0]   = b;
            endcase
        end
        else
        begin
            case (cnt_reg)
                2'd0:    grp_new[23:18] = ch_val[5:0];
                2'd1:    grp_new[17:12] = ch_val[5:0];
                2'd2:    grp_new[11:6]  = ch_val[5:0];
                default: grp_new[5:0]   = ch_val[5:0];
            endcase
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        grp_next  = grp_reg;
        cnt_next  = cnt_reg;
        pad_next  = pad_reg;
        err_next  = err_reg;
        job_push  = 1'b0;
        job       = '0;
        job.kind  = JOB_ENC;
        job.status = STATUS_OK;
        if (cfg_we)
        begin
            mode_next = mode_t'(cfg_wdata);
            grp_next  = '0;
            cnt_next  = '0;
            pad_next  = 1'b0;
            err_next  = 1'b0;
        end
        else if (accept)
        begin
            if (mode_reg == MODE_ENCODE)
            begin
                if (cnt_reg != 2'd2 && !last)
                begin
                    grp_next = grp_new;
                    cnt_next = cnt_reg + 2'd1;
                end
                else
                begin
                    job_push  = 1'b1;
                    job.kind  = JOB_ENC;
                    job.bits  = grp_new;
                    job.slots = 4'b1111;
                    job.last  = last;
                    case (cnt_reg)
                        2'd0:    job.pads = 4'b1100;
                        2'd1:    job.pads = 4'b1000;
                        default: job.pads = 4'b0000;
                    endcase
                    grp_next = '0;
                    cnt_next = '0;
                    pad_next = 1'b0;
                end
            end
            else if (err_reg)
            begin
                if (last)
                begin
                    err_next = 1'b0;
                    grp_next = '0;
                    cnt_next = '0;
                    pad_next = 1'b0;
                end
            end
            else if (ch_val[6])
            begin
                job_push   = 1'b1;
                job.kind   = JOB_ERR;
                job.slots  = 4'b0001;
                job.last   = 1'b1;
                job.status = STATUS_BAD_CHAR;
                grp_next   = '0;
                cnt_next   = '0;
                pad_next   = 1'b0;
                err_next   = !last;
            end
            else if (cnt_reg != 2'd3)
            begin
                if (last)
                begin
                    job_push   = 1'b1;
                    job.kind   = JOB_ERR;
                    job.slots  = 4'b0001;
                    job.last   = 1'b1;
                    job.status = STATUS_BAD_LEN;
                    grp_next   = '0;
                    cnt_next   = '0;
                    pad_next   = 1'b0;
                end
                else
                begin
                    grp_next = grp_new;
                    cnt_next = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd2 && b == CHAR_PAD)
                    begin
                        pad_next = 1'b1;
                    end
                end
            end
            else
            begin
                job_push  = 1'b1;
                job.kind  = JOB_DEC;
                job.bits  = grp_new;
                job.slots = {1'b0, b != CHAR_PAD, !pad_reg, 1'b1};
                job.last  = last;
                grp_next  = '0;
                cnt_next  = '0;
                pad_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ENCODE;
            grp_reg  <= '0;
            cnt_reg  <= '0;
            pad_reg  <= 1'b0;
            err_reg  <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            grp_reg  <= grp_next;
            cnt_reg  <= cnt_next;
            pad_reg  <= pad_next;
            err_reg  <= err_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/b64c_queue.sv */
`default_nettype none

module b64c_queue #(
    parameter int DEPTH = b64c_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire b64c_pkg::job_t  wr_job,
    output logic                 full,
    input  wire logic            rd_en,
    output logic                 rd_valid,
    output b64c_pkg::job_t       rd_job
);
    import b64c_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_job   = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/b64c_back.sv */
`default_nettype none

module b64c_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             job_valid,
    input  wire b64c_pkg::job_t   job_in,
    output logic                  job_pop,
    output logic                  empty,
    input  wire logic             pop,
    output b64c_pkg::out_item_t   out_item
);
    import b64c_pkg::*;

    job_t       job_reg, job_next;
    logic [3:0] slots_reg, slots_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;

    logic       fire;
    logic       load;
    logic [1:0] sel;
    logic [3:0] rest;
    logic [5:0] sextet;
    out_item_t  res;

    assign fire = (slots_reg != '0) && (!out_valid_reg || pop);
    assign rest = slots_reg & (slots_reg - 4'd1);
    assign load = job_valid && ((slots_reg == '0) || (fire && rest == '0));
    assign job_pop = load;

    // lowest pending slot goes first
    always_comb
    begin
        if (slots_reg[0])
        begin
            sel = 2'd0;
        end
        else if (slots_reg[1])
        begin
            sel = 2'd1;
        end
        else if (slots_reg[2])
        begin
            sel = 2'd2;
        end
        else
        begin
            sel = 2'd3;
        end
    end

    always_comb
    begin
        case (sel)
            2'd0:    sextet = job_reg.bits[23:18];
            2'd1:    sextet = job_reg.bits[17:12];
            2'd2:    sextet = job_reg.bits[11:6];
            default: sextet = job_reg.bits[5:0];
        endcase
    end

    always_comb
    begin
        res          = '0;
        res.status   = STATUS_OK;
        res.out_last = job_reg.last && (rest == '0);
        case (job_reg.kind)
            JOB_ENC:
            begin
                res.out_byte = job_reg.pads[sel] ? CHAR_PAD : b64c_char(sextet);
            end
            JOB_DEC:
            begin
                case (sel)
                    2'd0:    res.out_byte = job_reg.bits[23:16];
                    2'd1:    res.out_byte = job_reg.bits[15:8];
                    default: res.out_byte = job_reg.bits[7:0];
                endcase
            end
            default:
            begin
                res.out_byte = '0;
                res.status   = job_reg.status;
            end
        endcase
    end

    always_comb
    begin
        job_next       = job_reg;
        slots_next     = slots_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            slots_next     = rest;
            out_next       = res;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            job_next   = job_in;
            slots_next = job_in.slots;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slots_reg     <= slots_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

`ifndef SYNTH
    // every job carries at least one beat
    a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (slots_reg != '0))
        else $error("loaded job has no pending beats");

    // a decoded quad never yields a fourth byte
    a_dec_three: assert property (@(posedge clk) disable iff (!rst_n)
        (slots_reg != '0 && job_reg.kind == JOB_DEC) |-> !slots_reg[3])
        else $error("decode job with fourth slot");

    // a status beat always closes the message
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != STATUS_OK) |-> out_reg.out_last)
        else $error("status beat without last");

    // a new job is taken only once the current one is drained
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (load && slots_reg != '0) |-> (fire && rest == '0))
        else $error("job overwritten with beats pending");
`endif

endmodule

`default_nettype wire

/* test/tb_base64_codec_unit.sv */
`timescale 1ns / 1ps

module tb_base64_codec_unit;

    import b64c_pkg::*;

    localparam string B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 16;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic      cfg_wdata = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_item_t  in_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    out_item_t out_item;

    base64_codec_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // codec state as seen from outside
    mode_t       cur_mode = MODE_ENCODE;
    logic [23:0] grp_bits = '0;
    logic [1:0]  grp_cnt = '0;
    logic        third_pad = 1'b0;
    logic        dropping = 1'b0;

    in_item_t    byte_backlog [$];
    out_item_t   owed_results [$];
    out_item_t   head_result;

    int  send_idle_pct = 0;
    int  stall_pct = 0;
    int  phase_no = 0;
    int  beat_no = 0;
    int  mismatch_count = 0;
    logic rx_hold = 1'b0;
    logic stuck = 1'b0;

    task automatic report_mismatch(input string what);
        $display("%0t ns result beat %0d: %s", $time, beat_no, what);
        mismatch_count++;
    endtask

    function automatic int b64_sextet(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return int'(c) - "A";
        if (c >= "a" && c <= "z")
            return int'(c) - "a" + 26;
        if (c >= "0" && c <= "9")
            return int'(c) - "0" + 52;
        if (c == CHAR_PLUS)
            return 62;
        if (c == CHAR_SLASH)
            return 63;
        if (c == CHAR_PAD)
            return 0;
        return -1;
    endfunction

    task automatic owe(input logic [7:0] b, input logic l, input status_t s);
        out_item_t r;
        r.out_byte = b;
        r.out_last = l;
        r.status   = s;
        owed_results.push_back(r);
    endtask

    task automatic clear_group();
        grp_bits  = '0;
        grp_cnt   = '0;
        third_pad = 1'b0;
    endtask

    task automatic predict_codec_out(input in_item_t it);
        int   held;
        int   v;
        logic keep2;
        logic keep3;
        logic [7:0] ch;
        if (cur_mode == MODE_ENCODE)
        begin
            grp_bits = grp_bits | ({16'b0, it.in_byte} << (16 - 8 * int'(grp_cnt)));
            held = int'(grp_cnt) + 1;
            if (held < 3 && !it.in_last)
            begin
                grp_cnt = 2'(held);
            end
            else
            begin
                for (int k = 0; k < 4; k++)
                begin
                    if (k <= held)
                        ch = B64_ALPHABET[int'((grp_bits >> (18 - 6 * k)) & 24'h3F)];
                    else
                        ch = CHAR_PAD;
                    owe(ch, (k == 3) ? it.in_last : 1'b0, STATUS_OK);
                end
                clear_group();
            end
        end
        else if (dropping)
        begin
            if (it.in_last)
            begin
                dropping = 1'b0;
                clear_group();
            end
        end
        else
        begin
            v = b64_sextet(it.in_byte);
            if (v < 0)
            begin
                owe(8'h00, 1'b1, STATUS_BAD_CHAR);
                clear_group();
                dropping = !it.in_last;
            end
            else
            begin
                grp_bits = grp_bits | (24'(v) << (18 - 6 * int'(grp_cnt)));
                if (grp_cnt < 2'd3)
                begin
                    if (grp_cnt == 2'd2 && it.in_byte == CHAR_PAD)
                        third_pad = 1'b1;
                    grp_cnt = grp_cnt + 2'd1;
                    if (it.in_last)
                    begin
                        owe(8'h00, 1'b1, STATUS_BAD_LEN);
                        clear_group();
                    end
                end
                else
                begin
                    keep2 = !third_pad;
                    keep3 = (it.in_byte != CHAR_PAD);
                    owe(grp_bits[23:16], (!keep2 && !keep3) ? it.in_last : 1'b0, STATUS_OK);
                    if (keep2)
                        owe(grp_bits[15:8], keep3 ? 1'b0 : it.in_last, STATUS_OK);
                    if (keep3)
                        owe(grp_bits[7:0], it.in_last, STATUS_OK);
                    clear_group();
                end
            end
        end
    endtask

    // driver: acceptance and register writes seen at the rising edge
    always @(posedge clk)
    begin
        if (cfg_we)
        begin
            cur_mode = mode_t'(cfg_wdata);
            dropping = 1'b0;
            clear_group();
        end
        stuck = push && full;
        if (push && !full)
        begin
            predict_codec_out(in_item);
            void'(byte_backlog.pop_front());
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && !stuck)
        begin
            if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                push    <= 1'b1;
                in_item <= byte_backlog[0];
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // monitor
    always @(negedge clk)
    begin
        pop <= rst_n && !rx_hold && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            if (owed_results.size() == 0)
            begin
                report_mismatch("result beat with nothing owed");
            end
            else
            begin
                head_result = owed_results.pop_front();
                if (out_item.out_byte !== head_result.out_byte)
                    report_mismatch($sformatf("out_byte got %02h want %02h",
                        out_item.out_byte, head_result.out_byte));
                if (out_item.out_last !== head_result.out_last)
                    report_mismatch($sformatf("out_last got %b want %b",
                        out_item.out_last, head_result.out_last));
                if (out_item.status !== head_result.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                        out_item.status, head_result.status));
            end
            beat_no++;
        end
    end

    task automatic add_item(input logic [7:0] b, input logic l);
        in_item_t it;
        it.in_byte = b;
        it.in_last = l;
        byte_backlog.push_back(it);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_item(s[i], i == s.len() - 1);
    endtask

    task automatic add_enc_msg(inout int n);
        int len;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
            add_item(8'($urandom_range(255)), i == len - 1);
        n += len;
    endtask

    // mostly well-formed quads, some with stray bytes, short tails or pure noise
    task automatic add_dec_msg(inout int n);
        logic [7:0] txt [$];
        int nq;
        int r;
        nq = $urandom_range(1, 3);
        for (int i = 0; i < 4 * nq; i++)
            txt.push_back(B64_ALPHABET[$urandom_range(63)]);
        if ($urandom_range(2) == 0)
            txt[4 * nq - 2] = CHAR_PAD;
        if ($urandom_range(2) == 0)
            txt[4 * nq - 1] = CHAR_PAD;
        if ($urandom_range(9) == 0)
            txt[$urandom_range(4 * nq - 1)] = CHAR_PAD;
        r = $urandom_range(99);
        if (r < 15)
        begin
            txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
        end
        else if (r < 27)
        begin
            repeat ($urandom_range(1, 3)) void'(txt.pop_back());
        end
        else if (r < 35)
        begin
            txt.delete();
            repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(255)));
        end
        foreach (txt[i])
            add_item(txt[i], i == txt.size() - 1);
        n += txt.size();
    endtask

    task automatic fill_random();
        int n;
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            if (cur_mode == MODE_ENCODE)
                add_enc_msg(n);
            else
                add_dec_msg(n);
        end
    endtask

    task automatic drain();
        while (byte_backlog.size() != 0 || owed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic start_phase(input mode_t m, input int idle_pct, input int hold_pct);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        phase_no++;
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        start_phase(MODE_ENCODE, 0, 0);
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'h80, 1'b1);
        add_item(8'hFF, 1'b1);
        add_item(8'h7F, 1'b0);
        add_item(8'h01, 1'b1);
        // partial group left open, cleared by the mode write
        add_item(8'h55, 1'b0);

        start_phase(MODE_DECODE, 0, 0);
        add_text("//==");
        add_text("zz=9");
        add_text("=A+=");
        add_text("A*BC");
        add_text("AB");
        add_text("#");

        start_phase(MODE_ENCODE, 0, 0);
        fill_random();

        start_phase(MODE_DECODE, 80, 0);
        fill_random();

        start_phase(MODE_ENCODE, 0, 80);
        fill_random();

        start_phase(MODE_DECODE, 28, 28);
        fill_random();

        start_phase(MODE_ENCODE, 28, 28);
        fill_random();

        drain();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // long receiver hold-off while the sender keeps offering beats
    initial
    begin
        wait (phase_no == 3);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
